// ----- rtl/core/mjdr_pkg.sv -----
// ----------------------------------------------------------------------------
// mjdr_pkg
// Shared types, register indexes and constants for the motor jam detector.
// ----------------------------------------------------------------------------
package mjdr_pkg;

  localparam int unsigned AddrWidth = 5;

  localparam logic [32:0] ArriveTol      = 33'd128;
  localparam logic [32:0] ArriveSpeedTol = 33'd3200;

  localparam logic [1:0] LoopAngle = 2'd1;
  localparam logic [1:0] LoopSpeed = 2'd2;

  localparam logic KindTick  = 1'b0;
  localparam logic KindReset = 1'b1;

  typedef enum logic [1:0] {
    ST_NORMAL    = 2'd0,
    ST_SUSPECT   = 2'd1,
    ST_CONFIRMED = 2'd2,
    ST_HANDLING  = 2'd3
  } jam_state_t;

  typedef enum logic [2:0] {
    REG_CURRENT_LIMIT       = 3'd0,
    REG_SUSPECT_TIME_MS     = 3'd1,
    REG_RECOVER_TIME_MS     = 3'd2,
    REG_BACK_OFF_ANGLE      = 3'd3,
    REG_STALL_SPEED_LIMIT   = 3'd4,
    REG_ANGLE_COMMAND_FLOOR = 3'd5,
    REG_SPEED_COMMAND_FLOOR = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [14:0] current_limit;
    logic [15:0] suspect_time_ms;
    logic [15:0] recover_time_ms;
    logic [19:0] back_off_angle;
    logic [19:0] stall_speed_limit;
    logic [19:0] angle_command_floor;
    logic [19:0] speed_command_floor;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        time_ms;
    logic signed [15:0] current;
    logic signed [31:0] angle;
    logic signed [31:0] reference;
    logic signed [31:0] speed;
    logic [1:0]         loop_mode;
  } sample_t;

  typedef struct packed {
    logic [1:0]         jam_state;
    logic               drive_angle_loop;
    logic signed [31:0] angle_target;
  } result_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? (33'd0 - v) : v;
  endfunction

endpackage

// ----- rtl/core/motor_jam_detect_recover_core.sv -----
// ----------------------------------------------------------------------------
// motor_jam_detect_recover_core
// Motor jam detector and back-off recovery sequencer with a sample register,
// a single evaluation pass and a result register.
// ----------------------------------------------------------------------------
// A transferred sample is held in the sample register, evaluated, and its
// result is loaded into the result register once that register is free.
// Throughput: one sample per cycle while result_ready holds; the sample and
// result registers let a new transfer be taken while a finished result waits.
// Reset: synchronous; state returns to normal, timestamps and target to zero,
// configuration to its defaults, and both pipeline registers empty.
module motor_jam_detect_recover_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  mjdr_pkg::sample_t              sample,
  output logic                           result_valid,
  input  logic                           result_ready,
  output mjdr_pkg::result_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mjdr_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mjdr_pkg::*;

  cfg_t    cfg;
  sample_t held;
  logic    held_valid;
  logic    advance;
  logic    result_free;
  result_t step_result;

  mjdr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign result_free  = !result_valid || result_ready;
  assign advance      = held_valid && result_free;
  assign sample_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_ready) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      held <= sample;
    end
  end

  mjdr_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .item    (held),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !held_valid)
    else $error("pipeline not empty after reset");

  a_drive_state: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.drive_angle_loop |->
      (result.jam_state == ST_HANDLING) || (result.jam_state == ST_NORMAL))
    else $error("angle loop driven outside handling");

  a_target_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.drive_angle_loop |-> result.angle_target == 32'sd0)
    else $error("target not zero while angle loop is idle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> !$past(advance))
    else $error("result register overwritten while stalled");

endmodule

// ----- rtl/core/mjdr_regs.sv -----
// ----------------------------------------------------------------------------
// mjdr_regs
// Configuration register file with an APB-style access port.
// ----------------------------------------------------------------------------
module mjdr_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mjdr_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output mjdr_pkg::cfg_t                     cfg
);
  import mjdr_pkg::*;

  logic [2:0] index;
  logic       write_en;

  assign index    = paddr[AddrWidth-1:2];
  assign pready   = 1'b1;
  assign write_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_limit       <= 15'd3000;
      cfg.suspect_time_ms     <= 16'd150;
      cfg.recover_time_ms     <= 16'd800;
      cfg.back_off_angle      <= 20'd720;
      cfg.stall_speed_limit   <= 20'd3200;
      cfg.angle_command_floor <= 20'd1600;
      cfg.speed_command_floor <= 20'd1600;
    end else if (write_en) begin
      unique case (index)
        REG_CURRENT_LIMIT:       cfg.current_limit       <= pwdata[14:0];
        REG_SUSPECT_TIME_MS:     cfg.suspect_time_ms     <= pwdata[15:0];
        REG_RECOVER_TIME_MS:     cfg.recover_time_ms     <= pwdata[15:0];
        REG_BACK_OFF_ANGLE:      cfg.back_off_angle      <= pwdata[19:0];
        REG_STALL_SPEED_LIMIT:   cfg.stall_speed_limit   <= pwdata[19:0];
        REG_ANGLE_COMMAND_FLOOR: cfg.angle_command_floor <= pwdata[19:0];
        REG_SPEED_COMMAND_FLOOR: cfg.speed_command_floor <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_CURRENT_LIMIT:       prdata = {17'd0, cfg.current_limit};
      REG_SUSPECT_TIME_MS:     prdata = {16'd0, cfg.suspect_time_ms};
      REG_RECOVER_TIME_MS:     prdata = {16'd0, cfg.recover_time_ms};
      REG_BACK_OFF_ANGLE:      prdata = {12'd0, cfg.back_off_angle};
      REG_STALL_SPEED_LIMIT:   prdata = {12'd0, cfg.stall_speed_limit};
      REG_ANGLE_COMMAND_FLOOR: prdata = {12'd0, cfg.angle_command_floor};
      REG_SPEED_COMMAND_FLOOR: prdata = {12'd0, cfg.speed_command_floor};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/mjdr_step.sv -----
// ----------------------------------------------------------------------------
// mjdr_step
// Jam condition evaluation and the detect/recover state machine with its
// timestamp and target registers.
// ----------------------------------------------------------------------------
module mjdr_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  mjdr_pkg::cfg_t    cfg,
  input  mjdr_pkg::sample_t item,
  output mjdr_pkg::result_t result
);
  import mjdr_pkg::*;

  jam_state_t         mode;
  jam_state_t         mode_next;
  logic [31:0]        suspect_start;
  logic [31:0]        handling_start;
  logic signed [31:0] back_off_target;

  logic signed [32:0] angle_x;
  logic signed [32:0] speed_x;
  logic signed [32:0] ref_x;
  logic [32:0]        err_mag;
  logic [32:0]        ref_mag;
  logic [32:0]        cur_mag;
  logic [32:0]        spd_mag;
  logic [32:0]        arrive_mag;
  logic signed [32:0] back_off_raw;
  logic signed [31:0] back_off_sat;
  logic [31:0]        suspect_elapsed;
  logic [31:0]        handling_elapsed;
  logic               angle_active;
  logic               speed_active;
  logic               jam;
  logic               arrived;
  logic               is_reset;

  assign is_reset = (item.kind == KindReset);
  assign angle_x  = {item.angle[31], item.angle};
  assign speed_x  = {item.speed[31], item.speed};
  assign ref_x    = {item.reference[31], item.reference};

  assign err_mag    = mag33(ref_x - angle_x);
  assign ref_mag    = mag33(ref_x);
  assign cur_mag    = mag33({{17{item.current[15]}}, item.current});
  assign spd_mag    = mag33(speed_x);
  assign arrive_mag = mag33(angle_x - {back_off_target[31], back_off_target});

  assign angle_active = (item.loop_mode == LoopAngle) &&
                        (err_mag > {13'd0, cfg.angle_command_floor});
  assign speed_active = (item.loop_mode == LoopSpeed) &&
                        (ref_mag > {13'd0, cfg.speed_command_floor});
  assign jam = (angle_active || speed_active) &&
               (cur_mag > {18'd0, cfg.current_limit}) &&
               (spd_mag < {13'd0, cfg.stall_speed_limit});
  assign arrived = (arrive_mag <= ArriveTol) && (spd_mag <= ArriveSpeedTol);

  assign back_off_raw = angle_x - $signed({13'd0, cfg.back_off_angle});
  assign back_off_sat = (back_off_raw[32] && !back_off_raw[31]) ?
                        32'sh8000_0000 : back_off_raw[31:0];

  assign suspect_elapsed  = item.time_ms - suspect_start;
  assign handling_elapsed = item.time_ms - handling_start;

  always_comb begin
    mode_next = mode;
    if (is_reset) begin
      mode_next = ST_NORMAL;
    end else begin
      unique case (mode)
        ST_NORMAL: begin
          if (jam) mode_next = ST_SUSPECT;
        end
        ST_SUSPECT: begin
          if (!jam) begin
            mode_next = ST_NORMAL;
          end else if (suspect_elapsed > {16'd0, cfg.suspect_time_ms}) begin
            mode_next = ST_CONFIRMED;
          end
        end
        ST_CONFIRMED: mode_next = ST_HANDLING;
        ST_HANDLING: begin
          if (arrived || (handling_elapsed > {16'd0, cfg.recover_time_ms})) begin
            mode_next = ST_NORMAL;
          end
        end
        default: mode_next = ST_NORMAL;
      endcase
    end
  end

  always_comb begin
    result.jam_state        = mode_next;
    result.drive_angle_loop = 1'b0;
    result.angle_target     = 32'sd0;
    if (!is_reset) begin
      unique case (mode)
        ST_CONFIRMED: begin
          result.drive_angle_loop = 1'b1;
          result.angle_target     = back_off_sat;
        end
        ST_HANDLING: begin
          result.drive_angle_loop = 1'b1;
          result.angle_target     = back_off_target;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= ST_NORMAL;
      suspect_start   <= 32'd0;
      handling_start  <= 32'd0;
      back_off_target <= 32'sd0;
    end else if (advance) begin
      mode <= mode_next;
      if (is_reset) begin
        suspect_start   <= 32'd0;
        handling_start  <= 32'd0;
        back_off_target <= item.angle;
      end else if (mode == ST_NORMAL && jam) begin
        suspect_start <= item.time_ms;
      end else if (mode == ST_CONFIRMED) begin
        handling_start  <= item.time_ms;
        back_off_target <= back_off_sat;
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor jam detector and recovery sequencer.
// Samples are sent over the input channel while a local model of the jam
// state machine predicts the verdict for each one. Every result transfer is
// compared field by field against the oldest prediction. The register port is
// exercised with reads, writes, width masking and an unused address. Traffic
// runs under several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import mjdr_pkg::*;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned SegmentItems = 225;
  localparam int RegCount = REG_SPEED_COMMAND_FLOOR + 1;

  localparam logic [1:0] LoopOther  = 2'd0;
  localparam logic [1:0] LoopUnused = 2'd3;
  localparam logic [AddrWidth-1:0] UnusedAddr = {3'd7, 2'b00};

  localparam int AngleMin = 32'sh8000_0000;
  localparam int AngleMax = 32'sh7FFF_FFFF;
  localparam logic signed [33:0] TargetFloor = -34'sd2147483648;
  localparam logic [33:0] ArrivalWindow = 34'd128;
  localparam logic [33:0] ArrivalSpeed  = 34'd3200;

  localparam cfg_t DefaultCfg = '{
    current_limit:       15'd3000,
    suspect_time_ms:     16'd150,
    recover_time_ms:     16'd800,
    back_off_angle:      20'd720,
    stall_speed_limit:   20'd3200,
    angle_command_floor: 20'd1600,
    speed_command_floor: 20'd1600
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Local copy of the jam state machine and its registers.
  cfg_t cfg_model = DefaultCfg;
  jam_state_t jam_mode = ST_NORMAL;
  logic [31:0] suspect_t0 = '0;
  logic [31:0] handling_t0 = '0;
  logic signed [31:0] target_hold = '0;

  result_t expected_verdicts[$];
  result_t want;
  logic [31:0] sim_ms = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_remaining = 0;
  int unsigned cycle_count = 0;
  int error_count = 0;

  motor_jam_detect_recover_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** motor_jam_detect_recover_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_remaining != 0) begin
      result_ready <= 1'b0;
      hold_remaining--;
    end else begin
      result_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transfer with no prediction pending: %p", result);
        error_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (result.jam_state !== want.jam_state) begin
          $error("jam_state: expected %0d, actual %0d", want.jam_state, result.jam_state);
          error_count++;
        end
        if (result.drive_angle_loop !== want.drive_angle_loop) begin
          $error("drive_angle_loop: expected %0d, actual %0d",
                 want.drive_angle_loop, result.drive_angle_loop);
          error_count++;
        end
        if (result.angle_target !== want.angle_target) begin
          $error("angle_target: expected %0d, actual %0d",
                 want.angle_target, result.angle_target);
          error_count++;
        end
      end
    end
  end

  function automatic logic [33:0] magnitude(input logic signed [33:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void predict_jam_step(input sample_t s);
    logic signed [33:0] ang, ref_v, spd, cur, held, aim;
    logic [31:0] elapsed;
    logic loop_busy, jammed, arrived;
    result_t r;
    ang = s.angle;
    ref_v = s.reference;
    spd = s.speed;
    cur = s.current;
    held = target_hold;
    r = '0;
    if (s.kind == KindReset) begin
      jam_mode = ST_NORMAL;
      suspect_t0 = '0;
      handling_t0 = '0;
      target_hold = s.angle;
    end else begin
      loop_busy = (s.loop_mode == LoopAngle &&
                   magnitude(ref_v - ang) > 34'(cfg_model.angle_command_floor)) ||
                  (s.loop_mode == LoopSpeed &&
                   magnitude(ref_v) > 34'(cfg_model.speed_command_floor));
      jammed = loop_busy && magnitude(cur) > 34'(cfg_model.current_limit) &&
               magnitude(spd) < 34'(cfg_model.stall_speed_limit);
      case (jam_mode)
        ST_NORMAL: begin
          if (jammed) begin
            jam_mode = ST_SUSPECT;
            suspect_t0 = s.time_ms;
          end
        end
        ST_SUSPECT: begin
          elapsed = s.time_ms - suspect_t0;
          if (!jammed) begin
            jam_mode = ST_NORMAL;
          end else if (elapsed > 32'(cfg_model.suspect_time_ms)) begin
            jam_mode = ST_CONFIRMED;
          end
        end
        ST_CONFIRMED: begin
          aim = ang - 34'(cfg_model.back_off_angle);
          if (aim < TargetFloor) begin
            aim = TargetFloor;
          end
          target_hold = aim[31:0];
          handling_t0 = s.time_ms;
          jam_mode = ST_HANDLING;
          r.drive_angle_loop = 1'b1;
          r.angle_target = aim[31:0];
        end
        default: begin
          elapsed = s.time_ms - handling_t0;
          arrived = magnitude(ang - held) <= ArrivalWindow && magnitude(spd) <= ArrivalSpeed;
          r.drive_angle_loop = 1'b1;
          r.angle_target = target_hold;
          if (arrived || elapsed > 32'(cfg_model.recover_time_ms)) begin
            jam_mode = ST_NORMAL;
          end
        end
      endcase
    end
    r.jam_state = jam_mode;
    expected_verdicts.push_back(r);
  endfunction

  function automatic logic [31:0] register_value(input reg_index_t idx);
    case (idx)
      REG_CURRENT_LIMIT:       return 32'(cfg_model.current_limit);
      REG_SUSPECT_TIME_MS:     return 32'(cfg_model.suspect_time_ms);
      REG_RECOVER_TIME_MS:     return 32'(cfg_model.recover_time_ms);
      REG_BACK_OFF_ANGLE:      return 32'(cfg_model.back_off_angle);
      REG_STALL_SPEED_LIMIT:   return 32'(cfg_model.stall_speed_limit);
      REG_ANGLE_COMMAND_FLOOR: return 32'(cfg_model.angle_command_floor);
      REG_SPEED_COMMAND_FLOOR: return 32'(cfg_model.speed_command_floor);
      default:                 return '0;
    endcase
  endfunction

  function automatic sample_t motor_sample(input logic kind, input logic [31:0] t,
                                           input int cur, input int ang, input int ref_v,
                                           input int spd, input logic [1:0] lm);
    sample_t s;
    s.kind = kind;
    s.time_ms = t;
    s.current = 16'(cur);
    s.angle = ang;
    s.reference = ref_v;
    s.speed = spd;
    s.loop_mode = lm;
    return s;
  endfunction

  // Outside handling most ticks follow a plausible jam episode with random content,
  // in handling some land near the back-off target; the rest are forced resets and unconstrained noise.
  function automatic sample_t next_motor_sample();
    sample_t s;
    int unsigned pick, span, lim;
    int mag_v;
    pick = $urandom_range(99, 0);
    span = ((jam_mode == ST_HANDLING) ? cfg_model.recover_time_ms
                                      : cfg_model.suspect_time_ms) / 3 + 2;
    sim_ms += $urandom_range(span, 0);
    s.kind = KindTick;
    s.time_ms = sim_ms;
    s.current = 16'($urandom);
    s.angle = $urandom;
    s.reference = $urandom;
    s.speed = $urandom;
    s.loop_mode = 2'($urandom);
    if (pick < 4) begin
      s.kind = KindReset;
    end else if (pick < 18) begin
      s.time_ms = $urandom;
    end else if (jam_mode == ST_HANDLING) begin
      if (pick < 58) begin
        s.angle = target_hold + $urandom_range(256, 0) - 128;
        s.speed = int'($urandom_range(6400, 0)) - 3200;
      end
    end else if (pick < 88) begin
      lim = cfg_model.current_limit;
      mag_v = (lim >= 32767) ? 32768 :
              $urandom_range(lim + 1, (lim + 2000 > 32767) ? 32767 : lim + 2000);
      s.current = 16'((mag_v == 32768 || $urandom_range(1, 0) != 0) ? -mag_v : mag_v);
      lim = cfg_model.stall_speed_limit;
      mag_v = (lim == 0) ? 0 : $urandom_range(lim - 1, 0);
      s.speed = ($urandom_range(1, 0) != 0) ? -mag_v : mag_v;
      if ($urandom_range(1, 0) != 0) begin
        mag_v = cfg_model.angle_command_floor + 1 + $urandom_range(4000, 0);
        s.loop_mode = LoopAngle;
        s.reference = s.angle + (($urandom_range(1, 0) != 0) ? -mag_v : mag_v);
      end else begin
        mag_v = cfg_model.speed_command_floor + 1 + $urandom_range(4000, 0);
        s.loop_mode = LoopSpeed;
        s.reference = ($urandom_range(1, 0) != 0) ? -mag_v : mag_v;
      end
    end
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    predict_jam_step(s);
  endtask

  task automatic wait_for_results();
    sample_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [AddrWidth-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr[AddrWidth-1:2])
      REG_CURRENT_LIMIT:       cfg_model.current_limit = data[14:0];
      REG_SUSPECT_TIME_MS:     cfg_model.suspect_time_ms = data[15:0];
      REG_RECOVER_TIME_MS:     cfg_model.recover_time_ms = data[15:0];
      REG_BACK_OFF_ANGLE:      cfg_model.back_off_angle = data[19:0];
      REG_STALL_SPEED_LIMIT:   cfg_model.stall_speed_limit = data[19:0];
      REG_ANGLE_COMMAND_FLOOR: cfg_model.angle_command_floor = data[19:0];
      REG_SPEED_COMMAND_FLOOR: cfg_model.speed_command_floor = data[19:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_registers();
    int k;
    reg_index_t idx;
    for (k = 0; k < RegCount; k++) begin
      idx = reg_index_t'(k);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== register_value(idx)) begin
        $error("%s: expected %0d, actual %0d", idx.name(), register_value(idx), prdata);
        error_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic apply_settings(input cfg_t c);
    reg_write({REG_CURRENT_LIMIT, 2'b00}, 32'(c.current_limit));
    reg_write({REG_SUSPECT_TIME_MS, 2'b00}, 32'(c.suspect_time_ms));
    reg_write({REG_RECOVER_TIME_MS, 2'b00}, 32'(c.recover_time_ms));
    reg_write({REG_BACK_OFF_ANGLE, 2'b00}, 32'(c.back_off_angle));
    reg_write({REG_STALL_SPEED_LIMIT, 2'b00}, 32'(c.stall_speed_limit));
    reg_write({REG_ANGLE_COMMAND_FLOOR, 2'b00}, 32'(c.angle_command_floor));
    reg_write({REG_SPEED_COMMAND_FLOOR, 2'b00}, 32'(c.speed_command_floor));
  endtask

  task automatic test_register_access();
    int k;
    check_registers();
    for (k = 0; k < RegCount; k++) begin
      reg_write({reg_index_t'(k), 2'b00}, 32'hFFFF_FFFF);
    end
    check_registers();
    apply_settings('0);
    check_registers();
    reg_write(UnusedAddr, 32'hFFFF_FFFF);
    check_registers();
    apply_settings(DefaultCfg);
    check_registers();
  endtask

  task automatic test_directed_samples();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_sample(motor_sample(KindReset, 32'd0, 0, AngleMin, 0, 0, LoopAngle));
    send_sample(motor_sample(KindTick, 32'd1000, 3001, 0, 1601, 3199, LoopAngle));
    send_sample(motor_sample(KindTick, 32'd1150, 3001, 0, -1601, -3199, LoopAngle));
    send_sample(motor_sample(KindTick, 32'd1151, -32768, 0, 1601, -3199, LoopAngle));
    send_sample(motor_sample(KindTick, 32'd1160, 0, AngleMin + 100, 0, 0, LoopOther));
    send_sample(motor_sample(KindTick, 32'd1200, 0, AngleMin + 129, 0, 0, LoopOther));
    send_sample(motor_sample(KindTick, 32'd1210, 0, AngleMin + 128, 0, -3200, LoopOther));
    send_sample(motor_sample(KindTick, 32'd5000, -3001, AngleMax, -1601, 0, LoopSpeed));
    send_sample(motor_sample(KindTick, 32'd5100, 3000, AngleMax, -1601, 0, LoopSpeed));
    send_sample(motor_sample(KindTick, 32'd5200, 16384, 0, AngleMax, 3199, LoopSpeed));
    send_sample(motor_sample(KindTick, 32'd5351, 16384, 0, AngleMin, 0, LoopSpeed));
    send_sample(motor_sample(KindTick, 32'd5400, 0, AngleMax, 0, 0, LoopOther));
    send_sample(motor_sample(KindTick, 32'd6200, 0, 0, 0, 0, LoopOther));
    send_sample(motor_sample(KindTick, 32'd6201, 0, 0, 0, 3200, LoopOther));
    send_sample(motor_sample(KindTick, 32'd7000, -16384, 0, 1000000, 0, LoopUnused));
    send_sample(motor_sample(KindTick, 32'd7001, 16384, 0, 1601, 3200, LoopAngle));
    send_sample(motor_sample(KindTick, 32'd7002, 16384, 0, 1600, 0, LoopAngle));
    // Suspect starts just before the timestamp wraps and confirms after it.
    send_sample(motor_sample(KindTick, 32'hFFFF_FF80, 16384, AngleMin, AngleMax, 0,
                             LoopAngle));
    send_sample(motor_sample(KindTick, 32'h0000_0017, 16384, AngleMin, AngleMax, 0,
                             LoopAngle));
    send_sample(motor_sample(KindReset, 32'h0000_0018, 0, 12345, 0, 0, LoopOther));
    send_sample(motor_sample(KindTick, 32'd100, 5000, 0, 5000, 0, LoopAngle));
    send_sample(motor_sample(KindTick, 32'd300, 5000, 0, 5000, 0, LoopAngle));
    send_sample(motor_sample(KindTick, 32'd301, 0, -5000, 0, AngleMin, LoopOther));
    send_sample(motor_sample(KindReset, 32'd302, -1, -1, -1, -1, LoopUnused));
    send_sample(motor_sample(KindTick, 32'd303, -16384, 0, 5000, AngleMin, LoopAngle));
    wait_for_results();
  endtask

  task automatic test_backpressure();
    int n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sim_ms = $urandom;
    hold_remaining = 64;
    for (n = 0; n < 30; n++) begin
      send_sample(next_motor_sample());
    end
    wait_for_results();
    hold_remaining = 40;
    for (n = 0; n < 12; n++) begin
      send_sample(next_motor_sample());
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    int k, n;
    for (k = 0; k < 6; k++) begin
      case (k % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
      endcase
      case (k)
        0: c = DefaultCfg;
        2: begin
          c.current_limit = 15'($urandom);
          c.suspect_time_ms = 16'($urandom);
          c.recover_time_ms = 16'($urandom);
          c.back_off_angle = 20'($urandom);
          c.stall_speed_limit = 20'($urandom);
          c.angle_command_floor = 20'($urandom);
          c.speed_command_floor = 20'($urandom);
        end
        3: c = '0;
        4: c = '1;
        default: begin
          c.current_limit = 15'($urandom_range(4000, 500));
          c.suspect_time_ms = 16'($urandom_range(20, 1));
          c.recover_time_ms = 16'($urandom_range(40, 1));
          c.back_off_angle = 20'($urandom_range(2000, 1));
          c.stall_speed_limit = 20'($urandom_range(5000, 100));
          c.angle_command_floor = 20'($urandom_range(3000, 1));
          c.speed_command_floor = 20'($urandom_range(3000, 1));
        end
      endcase
      wait_for_results();
      apply_settings(c);
      sim_ms = $urandom;
      for (n = 0; n < SegmentItems; n++) begin
        send_sample(next_motor_sample());
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed_samples();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("** motor_jam_detect_recover_core: PASSED **");
    end else begin
      $display("** motor_jam_detect_recover_core: FAILED **");
    end
    $finish;
  end

endmodule
